// ===== rtl/ltsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsf_pkg
// Shared types, constants and address table for the LCD text SysEx framer.
// ----------------------------------------------------------------------------
package ltsf_pkg;

  localparam int TextLen   = 8;
  localparam int SlotCount = 6;
  localparam int MsgLen    = 19;
  localparam int SlotW     = $clog2(SlotCount);
  localparam int MsgIdxW   = $clog2(MsgLen);
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;
  localparam int IdW       = 7;

  typedef logic [7:0]              byte_t;
  typedef logic [TextLen-1:0][7:0] text_t;
  typedef logic [MsgLen-1:0][7:0]  msg_t;
  typedef logic [SlotW-1:0]        slot_t;

  // Fixed message bytes
  localparam byte_t SysexStart = 8'hF0;
  localparam byte_t MfrId      = 8'h41;
  localparam byte_t ModelHi    = 8'h00;
  localparam byte_t CmdDt1     = 8'h12;
  localparam byte_t SysexEnd   = 8'hF7;
  localparam byte_t Space      = 8'h20;
  localparam logic [1:0] RowInvalid = 2'd3;

  localparam logic [IdW-1:0] DeviceIdReset = 7'd16;
  localparam logic [IdW-1:0] ModelIdReset  = 7'd62;

  // Configuration register indexes (selected by paddr[2])
  typedef enum logic {
    REG_DEVICE_ID = 1'b0,
    REG_MODEL_ID  = 1'b1
  } reg_idx_e;

  // Result of one character lane
  typedef struct packed {
    byte_t chr;      // padded character
    logic  ended;    // terminator seen at or before this position
    logic  differs;  // padded character differs from the shadow copy
  } lane_res_t;

  function automatic byte_t addr_hi(input logic [1:0] row, input logic side);
    byte_t r;
    r = 8'h00;
    if (row != 2'd0) begin
      r = side ? 8'h08 : 8'h04;
    end
    return r;
  endfunction

  function automatic byte_t addr_lo(input logic [1:0] row, input logic side);
    byte_t r;
    r = 8'h00;
    unique case (row)
      2'd0:    r = side ? 8'h08 : 8'h00;
      2'd1:    r = side ? 8'h20 : 8'h00;
      2'd2:    r = side ? 8'h60 : 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ltsf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsf_in_if / ltsf_out_if
// Valid/ready channels carrying text items in and message bytes out.
// ----------------------------------------------------------------------------
interface ltsf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row;
  logic        side;
  logic [7:0]  char_0;
  logic [7:0]  char_1;
  logic [7:0]  char_2;
  logic [7:0]  char_3;
  logic [7:0]  char_4;
  logic [7:0]  char_5;
  logic [7:0]  char_6;
  logic [7:0]  char_7;

  modport source (output valid, row, side, char_0, char_1, char_2, char_3,
                  char_4, char_5, char_6, char_7, input ready);
  modport sink   (input valid, row, side, char_0, char_1, char_2, char_3,
                  char_4, char_5, char_6, char_7, output ready);
endinterface

interface ltsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_message;

  modport source (output valid, out_byte, end_of_message, input ready);
  modport sink   (input valid, out_byte, end_of_message, output ready);
endinterface

// ===== rtl/ltsf_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsf_lane
// One character position: terminator padding and shadow compare.
// ----------------------------------------------------------------------------
module ltsf_lane (
  input  ltsf_pkg::byte_t     char_i,
  input  logic                ended_i,
  input  ltsf_pkg::byte_t     shadow_i,
  output ltsf_pkg::lane_res_t res_o
);

  logic ended;

  assign ended         = ended_i | (char_i == 8'h00);
  assign res_o.ended   = ended;
  assign res_o.chr     = ended ? ltsf_pkg::Space : char_i;
  assign res_o.differs = (res_o.chr != shadow_i);

endmodule

// ===== rtl/ltsf_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsf_merge
// Combines lane results: change detect, checksum and message assembly.
// ----------------------------------------------------------------------------
module ltsf_merge (
  input  ltsf_pkg::lane_res_t [ltsf_pkg::TextLen-1:0] lanes_i,
  input  logic [1:0]                                  row_i,
  input  logic                                        side_i,
  input  logic [ltsf_pkg::IdW-1:0]                    device_id_i,
  input  logic [ltsf_pkg::IdW-1:0]                    model_id_i,
  output logic                                        changed_o,
  output ltsf_pkg::text_t                             text_o,
  output ltsf_pkg::msg_t                              msg_o
);

  ltsf_pkg::byte_t ahi;
  ltsf_pkg::byte_t alo;
  logic [6:0]      sum;
  logic            any_diff;
  logic [6:0]      csum;

  assign ahi = ltsf_pkg::addr_hi(row_i, side_i);
  assign alo = ltsf_pkg::addr_lo(row_i, side_i);

  // Only the low 7 bits of the sum matter for the checksum
  always_comb begin
    sum      = ahi[6:0] + alo[6:0];
    any_diff = 1'b0;
    for (int i = 0; i < ltsf_pkg::TextLen; i++) begin
      sum       = sum + lanes_i[i].chr[6:0];
      any_diff  = any_diff | lanes_i[i].differs;
      text_o[i] = lanes_i[i].chr;
    end
  end

  assign csum      = 7'd0 - sum;
  assign changed_o = (row_i != ltsf_pkg::RowInvalid) && any_diff;

  always_comb begin
    msg_o[0] = ltsf_pkg::SysexStart;
    msg_o[1] = ltsf_pkg::MfrId;
    msg_o[2] = {1'b0, device_id_i};
    msg_o[3] = ltsf_pkg::ModelHi;
    msg_o[4] = ltsf_pkg::ModelHi;
    msg_o[5] = {1'b0, model_id_i};
    msg_o[6] = ltsf_pkg::CmdDt1;
    msg_o[7] = ahi;
    msg_o[8] = alo;
    for (int i = 0; i < ltsf_pkg::TextLen; i++) begin
      msg_o[9+i] = lanes_i[i].chr;
    end
    msg_o[ltsf_pkg::MsgLen-2] = {1'b0, csum};
    msg_o[ltsf_pkg::MsgLen-1] = ltsf_pkg::SysexEnd;
  end

endmodule

// ===== rtl/ltsf_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsf_serializer
// Message buffer that shifts one byte per output transaction.
// ----------------------------------------------------------------------------
module ltsf_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ltsf_pkg::msg_t      msg_i,
  output logic                can_load_o,
  ltsf_out_if.source          out_o
);

  localparam logic [ltsf_pkg::MsgIdxW-1:0] LastIdx =
    ltsf_pkg::MsgIdxW'(ltsf_pkg::MsgLen - 1);

  ltsf_pkg::msg_t                buf_q, buf_d;
  logic [ltsf_pkg::MsgIdxW-1:0]  idx_q, idx_d;
  logic                          valid_q, valid_d;
  logic                          fire;
  logic                          last;

  assign fire       = valid_q && out_o.ready;
  assign last       = (idx_q == LastIdx);
  assign can_load_o = !valid_q || (fire && last);

  always_comb begin
    buf_d   = buf_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      buf_d   = msg_i;
      idx_d   = '0;
      valid_d = 1'b1;
    end else if (fire) begin
      buf_d   = buf_q >> 8;
      idx_d   = idx_q + 1'b1;
      valid_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.out_byte       = buf_q[0];
  assign out_o.end_of_message = last;

endmodule

// ===== rtl/lcd_text_sysex_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_text_sysex_framer_unit
// Turns 8-character LCD row/side texts into DT1 SysEx byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transaction per text item (row, side, char_0..char_7).
//   out_o : one transaction per message byte; end_of_message marks the F7.
//   APB   : register 0 (addr 0) device_id, register 1 (addr 4) model_id.
//           Write only while the block is idle.
// Flow: an accepted item is held in the decision register; when it changes
//   its slot, the first byte (F0) is valid in the cycle after the serializer
//   loads it. A changed text is sent as 19 bytes, one per output transaction,
//   over the single-byte output port. Unchanged or invalid-row items retire
//   without waiting for the serializer. The next message is loaded in the same
//   cycle the previous F7 is taken, so back-to-back messages stream without gaps.
// Reset: all six shadow slots read as spaces, registers take their reset
//   ids, both channels empty.
// Stall: while the output is stalled the current byte holds, a changed item
//   waits in the decision register and in_i.ready drops until it can move on.
// ----------------------------------------------------------------------------
module lcd_text_sysex_framer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ltsf_in_if.sink                       in_i,
  ltsf_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltsf_pkg::PaddrW-1:0]   paddr,
  input  logic [ltsf_pkg::PdataW-1:0]   pwdata,
  output logic [ltsf_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ltsf_pkg::IdW-1:0] device_id_q, device_id_d;
  logic [ltsf_pkg::IdW-1:0] model_id_q, model_id_d;
  logic                     cfg_wr;
  ltsf_pkg::reg_idx_e       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ltsf_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    device_id_d = device_id_q;
    model_id_d  = model_id_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        ltsf_pkg::REG_DEVICE_ID: device_id_d = pwdata[ltsf_pkg::IdW-1:0];
        ltsf_pkg::REG_MODEL_ID:  model_id_d  = pwdata[ltsf_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ltsf_pkg::REG_DEVICE_ID:
        prdata = {{(ltsf_pkg::PdataW-ltsf_pkg::IdW){1'b0}}, device_id_q};
      ltsf_pkg::REG_MODEL_ID:
        prdata = {{(ltsf_pkg::PdataW-ltsf_pkg::IdW){1'b0}}, model_id_q};
      default: prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Decision register: holds one item while it is compared and framed
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  logic [1:0]      s1_row_q;
  logic            s1_side_q;
  ltsf_pkg::text_t s1_text_q;
  logic            in_fire;
  logic            s1_adv;
  logic            changed;
  logic            ser_can_load;
  logic            ser_load;

  assign s1_adv   = s1_valid_q && (!changed || ser_can_load);
  assign ser_load = s1_valid_q && changed && ser_can_load;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      device_id_q <= ltsf_pkg::DeviceIdReset;
      model_id_q  <= ltsf_pkg::ModelIdReset;
    end else begin
      device_id_q <= device_id_d;
      model_id_q  <= model_id_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q     <= in_i.row;
      s1_side_q    <= in_i.side;
      s1_text_q[0] <= in_i.char_0;
      s1_text_q[1] <= in_i.char_1;
      s1_text_q[2] <= in_i.char_2;
      s1_text_q[3] <= in_i.char_3;
      s1_text_q[4] <= in_i.char_4;
      s1_text_q[5] <= in_i.char_5;
      s1_text_q[6] <= in_i.char_6;
      s1_text_q[7] <= in_i.char_7;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow copies of the six slots (slot = row*2 + side)
  // --------------------------------------------------------------------------
  ltsf_pkg::text_t shadow_q [ltsf_pkg::SlotCount];
  ltsf_pkg::text_t shadow_rd;
  ltsf_pkg::text_t padded;
  ltsf_pkg::slot_t slot;
  logic            slot_ok;

  assign slot    = {s1_row_q, s1_side_q};
  assign slot_ok = (s1_row_q != ltsf_pkg::RowInvalid);
  // Invalid row never emits, so any slot content will do there
  assign shadow_rd = slot_ok ? shadow_q[slot] : shadow_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ltsf_pkg::SlotCount; s++) begin
        shadow_q[s] <= {ltsf_pkg::TextLen{ltsf_pkg::Space}};
      end
    end else if (ser_load) begin
      shadow_q[slot] <= padded;
    end
  end

  // --------------------------------------------------------------------------
  // Character lanes and merge
  // --------------------------------------------------------------------------
  ltsf_pkg::lane_res_t [ltsf_pkg::TextLen-1:0] lanes;
  logic [ltsf_pkg::TextLen:0]                  ended_chain;
  ltsf_pkg::msg_t                              msg;

  assign ended_chain[0] = 1'b0;

  for (genvar g = 0; g < ltsf_pkg::TextLen; g++) begin : g_lane
    ltsf_lane u_lane (
      .char_i   (s1_text_q[g]),
      .ended_i  (ended_chain[g]),
      .shadow_i (shadow_rd[g]),
      .res_o    (lanes[g])
    );
    assign ended_chain[g+1] = lanes[g].ended;
  end

  ltsf_merge u_merge (
    .lanes_i     (lanes),
    .row_i       (s1_row_q),
    .side_i      (s1_side_q),
    .device_id_i (device_id_q),
    .model_id_i  (model_id_q),
    .changed_o   (changed),
    .text_o      (padded),
    .msg_o       (msg)
  );

  // --------------------------------------------------------------------------
  // Output byte serializer
  // --------------------------------------------------------------------------
  ltsf_serializer u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ser_load),
    .msg_i      (msg),
    .can_load_o (ser_can_load),
    .out_o      (out_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An invalid row never starts a message
  a_invalid_row_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !slot_ok) |-> !ser_load)
    else $error("message started for invalid row");

  // After a load the slot holds the framed text
  a_shadow_updated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |=> (shadow_q[$past(slot)] == $past(padded)))
    else $error("shadow slot not updated with sent text");

  // A byte following a completed message starts a new one
  a_msg_starts_f0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.end_of_message)
      |=> (!out_o.valid || out_o.out_byte == ltsf_pkg::SysexStart))
    else $error("message does not start with F0");

endmodule

// ===== test/lcd_text_sysex_framer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_text_sysex_framer_unit_tb
// Self-checking bench for the LCD text SysEx framer. A table of directed text
// items runs first, then random phases under several device/model id
// settings. Each accepted text item is run through a local frame builder
// that keeps its own shadow of the six slots. Every outgoing byte is checked
// in order against the queue of bytes still due.
// ----------------------------------------------------------------------------
module lcd_text_sysex_framer_unit_tb;
  import ltsf_pkg::*;

  // Expected byte of an outgoing message
  typedef struct packed {
    byte_t data;
    logic  eom;
  } sysex_byte_t;

  // One row of the directed table; -1 in a typed field means "use the frame builder"
  typedef struct {
    logic [1:0] row;
    logic       side;
    text_t      txt;
    int         typed_len;
    int         typed_chk;
  } text_case_t;

  localparam int    ChkPos = MsgLen - 2;   // checksum position in the message
  localparam text_t Blank  = {TextLen{Space}};
  localparam text_t AllA   = {TextLen{8'h41}};
  localparam text_t AllFF  = {TextLen{8'hFF}};
  localparam text_t Zeros  = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  ltsf_in_if  text_if ();
  ltsf_out_if sysex_if ();

  // Local frame builder state
  text_t          shadow [SlotCount];
  logic [IdW-1:0] dev_id_q;
  logic [IdW-1:0] model_id_q;

  sysex_byte_t bytes_due [$];
  int          mismatches = 0;
  bit          calm = 1'b0;   // last phase: no idling on either side

  lcd_text_sysex_framer_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (text_if),
    .out_o   (sysex_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAIL lcd_text_sysex_framer_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Frame builder
  // --------------------------------------------------------------------------
  // Address table, indexed by {side, row}
  function automatic byte_t slot_addr_hi(input logic [1:0] row, input logic side);
    case ({side, row})
      3'b0_01, 3'b0_10: return 8'h04;
      3'b1_01, 3'b1_10: return 8'h08;
      default:          return 8'h00;
    endcase
  endfunction

  function automatic byte_t slot_addr_lo(input logic [1:0] row, input logic side);
    case ({side, row})
      3'b0_10: return 8'h40;
      3'b1_00: return 8'h08;
      3'b1_01: return 8'h20;
      3'b1_10: return 8'h60;
      default: return 8'h00;
    endcase
  endfunction

  // Pads the text, updates the shadow and builds the message; returns its length
  function automatic int build_frame(input logic [1:0] row, input logic side,
                                     input text_t txt, output msg_t msg);
    text_t       padded;
    logic        ended;
    int unsigned sum;
    int          slot;
    msg   = '0;
    ended = 1'b0;
    if (row == RowInvalid) return 0;
    for (int i = 0; i < TextLen; i++) begin
      if (txt[i] == 8'h00) ended = 1'b1;
      padded[i] = ended ? Space : txt[i];
    end
    slot = int'(row) * 2 + int'(side);
    if (shadow[slot] == padded) return 0;
    shadow[slot] = padded;
    msg[0] = SysexStart;
    msg[1] = MfrId;
    msg[2] = {1'b0, dev_id_q};
    msg[3] = ModelHi;   // two zero model bytes ahead of the model id
    msg[4] = ModelHi;
    msg[5] = {1'b0, model_id_q};
    msg[6] = CmdDt1;
    msg[7] = slot_addr_hi(row, side);
    msg[8] = slot_addr_lo(row, side);
    sum = int'(msg[7]) + int'(msg[8]);
    for (int i = 0; i < TextLen; i++) begin
      msg[9 + i] = padded[i];
      sum += padded[i];
    end
    msg[ChkPos]     = byte_t'((128 - (sum & 127)) & 127);
    msg[MsgLen - 1] = SysexEnd;
    return MsgLen;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // --------------------------------------------------------------------------
  // Output check: every byte transaction against the oldest byte due
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sysex_byte_t want;
    if (rst_ni && sysex_if.valid && sysex_if.ready) begin
      if (bytes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h eom %0b",
                                sysex_if.out_byte, sysex_if.end_of_message));
      end else begin
        want = bytes_due.pop_front();
        if (sysex_if.out_byte !== want.data || sysex_if.end_of_message !== want.eom) begin
          note_mismatch($sformatf("byte mismatch: expected %02h eom %0b, got %02h eom %0b",
                                  want.data, want.eom, sysex_if.out_byte,
                                  sysex_if.end_of_message));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output back-pressure: random stall bursts, with stall-free stretches
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int steady_left;
    stall_left     = 0;
    steady_left    = 0;
    sysex_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm || steady_left > 0) begin
        sysex_if.ready = 1'b1;
        if (steady_left > 0) steady_left--;
      end else if (stall_left > 0) begin
        sysex_if.ready = 1'b0;
        stall_left--;
      end else begin
        sysex_if.ready = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2: stall_left  = $urandom_range(1, 6);
          3:       steady_left = $urandom_range(20, 60);
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_ids();
    logic [31:0] rd;
    apb_xfer(1'b0, REG_DEVICE_ID, $urandom, rd);
    if (rd !== PdataW'(dev_id_q))
      note_mismatch($sformatf("device_id read %08h, expected %02h", rd, dev_id_q));
    apb_xfer(1'b0, REG_MODEL_ID, $urandom, rd);
    if (rd !== PdataW'(model_id_q))
      note_mismatch($sformatf("model_id read %08h, expected %02h", rd, model_id_q));
  endtask

  // Only called with the block idle; upper bits of the data are don't-care
  task automatic set_ids(input logic [31:0] dev_val, input logic [31:0] model_val);
    logic [31:0] rd;
    apb_xfer(1'b1, REG_DEVICE_ID, dev_val, rd);
    dev_id_q = dev_val[IdW-1:0];
    apb_xfer(1'b1, REG_MODEL_ID, model_val, rd);
    model_id_q = model_val[IdW-1:0];
    check_ids();
  endtask

  // Drive one text item, wait for its transaction, then queue what it should emit
  task automatic send_text(input logic [1:0] row, input logic side, input text_t txt,
                           input int typed_len, input int typed_chk);
    msg_t frame;
    int   len;
    @(negedge clk_i);
    text_if.row    = row;
    text_if.side   = side;
    text_if.char_0 = txt[0];
    text_if.char_1 = txt[1];
    text_if.char_2 = txt[2];
    text_if.char_3 = txt[3];
    text_if.char_4 = txt[4];
    text_if.char_5 = txt[5];
    text_if.char_6 = txt[6];
    text_if.char_7 = txt[7];
    text_if.valid  = 1'b1;
    do @(posedge clk_i); while (!text_if.ready);
    len = build_frame(row, side, txt, frame);
    if (typed_len >= 0) len = typed_len;
    if (typed_chk >= 0) frame[ChkPos] = byte_t'(typed_chk);
    for (int i = 0; i < len; i++) begin
      bytes_due.push_back('{frame[i], i == MsgLen - 1});
    end
  endtask

  // Random input gap now and then
  task automatic gap_in();
    if (!calm && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        text_if.valid = 1'b0;
      end
    end
  endtask

  // Sender holds off until every due byte is out, then lets an unchanged
  // item that may still sit in the decision register retire
  task automatic settle();
    @(negedge clk_i);
    text_if.valid = 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random text: mostly fresh printable text with a random terminator and
  // garbage after it, some raw bytes, some repeats of the slot's shadow
  function automatic text_t pick_text(input logic [1:0] row, input logic side);
    text_t t;
    int    mode;
    int    stop;
    mode = $urandom_range(0, 9);
    stop = $urandom_range(0, TextLen);
    for (int i = 0; i < TextLen; i++) t[i] = byte_t'($urandom_range(8'h21, 8'h7E));
    if (mode <= 1 && row != RowInvalid) begin
      t = shadow[int'(row) * 2 + int'(side)];
    end else if (mode <= 3) begin
      for (int i = 0; i < TextLen; i++) t[i] = byte_t'($urandom);
      if (mode == 3 && stop < TextLen) t[stop] = 8'h00;
    end else if (stop < TextLen) begin
      t[stop] = 8'h00;
    end
    return t;
  endfunction

  task automatic run_random(input int count);
    logic [1:0] row;
    logic       side;
    for (int n = 0; n < count; n++) begin
      row  = ($urandom_range(0, 11) == 0) ? RowInvalid : 2'($urandom_range(0, 2));
      side = 1'($urandom);
      send_text(row, side, pick_text(row, side), -1, -1);
      if ($urandom_range(0, 29) == 0) settle();
      gap_in();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    text_case_t dir_cases [$];

    // Known values on every input from time zero
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    text_if.valid  = 1'b0;
    text_if.row    = '0;
    text_if.side   = 1'b0;
    text_if.char_0 = '0;
    text_if.char_1 = '0;
    text_if.char_2 = '0;
    text_if.char_3 = '0;
    text_if.char_4 = '0;
    text_if.char_5 = '0;
    text_if.char_6 = '0;
    text_if.char_7 = '0;

    for (int s = 0; s < SlotCount; s++) shadow[s] = Blank;
    dev_id_q   = DeviceIdReset;
    model_id_q = ModelIdReset;

    // Directed table; concatenated texts list char_7 first
    // Slots read as spaces after reset, so blank text is no change
    dir_cases.push_back('{2'd0, 1'b0, Blank, 0, -1});
    dir_cases.push_back('{2'd0, 1'b1, Blank, 0, -1});
    // Invalid row never emits
    dir_cases.push_back('{RowInvalid, 1'b0, AllA, 0, -1});
    dir_cases.push_back('{RowInvalid, 1'b1, AllFF, 0, -1});
    // First real change, then the same text again
    dir_cases.push_back('{2'd0, 1'b0, AllA, MsgLen, 8'h78});
    dir_cases.push_back('{2'd0, 1'b0, AllA, 0, -1});
    // Top-bit characters pass through and wrap the checksum to zero
    dir_cases.push_back('{2'd0, 1'b1, AllFF, MsgLen, 8'h00});
    // Terminator at position 0: whole text turns to spaces
    dir_cases.push_back('{2'd0, 1'b0, Zeros, MsgLen, 8'h00});
    dir_cases.push_back('{2'd0, 1'b0, Zeros, 0, -1});
    // Text after the terminator is ignored: second item pads the same
    dir_cases.push_back('{2'd1, 1'b0,
        {8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h00, 8'h49, 8'h48}, -1, -1});
    dir_cases.push_back('{2'd1, 1'b0,
        {8'hFF, 8'h80, 8'h01, 8'h7E, 8'h00, 8'h00, 8'h49, 8'h48}, 0, -1});
    // Terminator in the last position
    dir_cases.push_back('{2'd2, 1'b0,
        {8'h00, 8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31}, -1, -1});
    dir_cases.push_back('{2'd2, 1'b1, 64'h8786_8584_8382_8180, -1, -1});
    dir_cases.push_back('{2'd1, 1'b1, AllA, -1, -1});
    dir_cases.push_back('{2'd2, 1'b0, Blank, -1, -1});
    dir_cases.push_back('{2'd1, 1'b1, {TextLen{8'h01}}, -1, -1});
    dir_cases.push_back('{2'd2, 1'b1, {TextLen{8'h7F}}, -1, -1});
    dir_cases.push_back('{2'd2, 1'b1, {TextLen{8'h7F}}, 0, -1});
    dir_cases.push_back('{2'd1, 1'b0, Blank, -1, -1});
    // Back to spaces on the right half of row 0
    dir_cases.push_back('{2'd0, 1'b1, Zeros, MsgLen, 8'h78});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    check_ids();
    foreach (dir_cases[k]) begin
      send_text(dir_cases[k].row, dir_cases[k].side, dir_cases[k].txt,
                dir_cases[k].typed_len, dir_cases[k].typed_chk);
      gap_in();
    end

    // Random phases: id extremes first, then random ids; last one without idling
    settle();
    set_ids({$urandom} | 32'h7F, {$urandom} & ~32'h7F);
    run_random(25);
    settle();
    set_ids({$urandom} & ~32'h7F, {$urandom} | 32'h7F);
    run_random(25);
    settle();
    set_ids($urandom, $urandom);
    run_random(25);
    settle();
    set_ids($urandom, $urandom);
    calm = 1'b1;
    run_random(25);
    settle();

    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("PASS lcd_text_sysex_framer_unit");
    end else begin
      $display("FAIL lcd_text_sysex_framer_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ltsf_pkg.sv
rtl/ltsf_if.sv
rtl/ltsf_lane.sv
rtl/ltsf_merge.sv
rtl/ltsf_serializer.sv
rtl/lcd_text_sysex_framer_unit.sv
test/lcd_text_sysex_framer_unit_tb.sv
